/* rtl/sli_pkg.sv */
`default_nettype none

package sli_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int ACT_W    = 2;
    localparam int STS_W    = 3;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;

    // Result status codes
    localparam logic [STS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STS_W-1:0] ST_ENTRY     = 3'd3;
    localparam logic [STS_W-1:0] ST_EMPTY     = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming action and value
        logic apply;       // run insert or remove and load its result
        logic emit_empty;  // load the empty-list result
        logic emit_entry;  // load the dump entry at the read index, advance it
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             out_free;
        logic             empty;
        logic             dump_last;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/sorted_list_insert_remove.sv */
`default_nettype none

// Sorted list of up to sli_pkg::CAPACITY signed 32-bit values, kept in
// ascending order in a row of compare cells. Insert (action 0) places the value
// ahead of the first stored value that is greater than or equal to it, so
// duplicates are kept; a full list answers "full" and drops the value. Remove
// (action 1) deletes the first equal value or answers "not found". Dump
// (action 2) streams every stored value in order with o_last on the final one,
// or a single "list empty" transfer. Action code 3 is taken and dropped with
// no result. Every cell compares against the latched value in parallel, so an
// insert or remove completes in a single update after the input transfer,
// taken once the output register is free. A dump streams its entries one per
// cycle through the single read mux on the cell row while the output is not
// stalled. The input stalls while an item is in progress; a finished result
// waiting in the output register does not block the next transfer in.

module sorted_list_insert_remove (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [sli_pkg::ACT_W-1:0]        i_action,
    input  wire logic signed [sli_pkg::VAL_W-1:0] i_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [sli_pkg::STS_W-1:0]             o_status,
    output logic signed [sli_pkg::VAL_W-1:0]      o_entry,
    output logic                                  o_last
);

    // command and status between controller and datapath
    sli_pkg::t_cmd  cmd;
    sli_pkg::t_stat stat;

    // Sequence each item: capture, update or stream, return to idle
    sli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold the cell row, fill count, latched item and output register
    sli_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_entry     (o_entry),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

/* rtl/sli_ctrl.sv */
`default_nettype none

module sli_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire sli_pkg::t_stat i_stat,
    output sli_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.action) inside
                    sli_pkg::ACT_INSERT, sli_pkg::ACT_REMOVE: begin
                        if (i_stat.out_free) begin
                            o_cmd.apply = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    sli_pkg::ACT_DUMP: begin
                        if (i_stat.out_free) begin
                            if (i_stat.empty) begin
                                o_cmd.emit_empty = 1'b1;
                                n_state          = S_IDLE;
                            end else begin
                                o_cmd.emit_entry = 1'b1;
                                n_state          = i_stat.dump_last ? S_IDLE : S_DUMP;
                            end
                        end
                    end
                    default: begin
                        // unused action code: drop the item
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/sli_dpath.sv */
`default_nettype none

module sli_dpath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sli_pkg::t_cmd               i_cmd,
    input  wire logic [sli_pkg::ACT_W-1:0]   i_action,
    input  wire logic signed [sli_pkg::VAL_W-1:0] i_value,
    input  wire logic                        i_out_stall,
    output sli_pkg::t_stat                   o_stat,
    output logic                             o_out_valid,
    output logic [sli_pkg::STS_W-1:0]        o_status,
    output logic signed [sli_pkg::VAL_W-1:0] o_entry,
    output logic                             o_last
);

    localparam int CAP = sli_pkg::CAPACITY;
    localparam int CW  = sli_pkg::CNT_W;
    localparam int IW  = sli_pkg::IDX_W;
    localparam int VW  = sli_pkg::VAL_W;

    // Cell row and fill count
    logic signed [VW-1:0] r_cell [CAP];
    logic signed [VW-1:0] n_cell [CAP];
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;

    // Latched item
    logic [sli_pkg::ACT_W-1:0] r_action;
    logic signed [VW-1:0]      r_value;
    logic [IW-1:0]             r_idx;

    // Output register
    logic                      r_out_valid;
    logic [sli_pkg::STS_W-1:0] r_status;
    logic signed [VW-1:0]      r_entry;
    logic                      r_last;

    logic [CAP-1:0] cell_valid;
    logic [CAP-1:0] ge;        // cell at or past the insert point
    logic [CAP-1:0] eq;        // stored cell equals the value
    logic [CAP-1:0] hit_upto;  // a match at this cell or before it
    logic           full;
    logic           found;
    logic           out_free;
    logic           dump_last;

    assign full      = (r_count == CW'(CAP));
    assign found     = hit_upto[CAP-1];
    assign out_free  = !r_out_valid || !i_out_stall;
    assign dump_last = ({1'b0, r_idx} + CW'(1)) == r_count;

    genvar k;
    generate
        for (k = 0; k < CAP; k++) begin : g_cell
            assign cell_valid[k] = r_count > CW'(k);
            assign ge[k] = !cell_valid[k] || (r_cell[k] >= r_value);
            assign eq[k] = cell_valid[k] && (r_cell[k] == r_value);
            assign hit_upto[k] = |eq[k:0];
        end
    endgenerate

    always_comb begin
        for (int j = 0; j < CAP; j++) begin
            n_cell[j] = r_cell[j];
        end
        n_count = r_count;
        if (i_cmd.apply) begin
            if (r_action == sli_pkg::ACT_INSERT) begin
                if (!full) begin
                    n_count = r_count + CW'(1);
                    if (ge[0]) begin
                        n_cell[0] = r_value;
                    end
                    for (int j = 1; j < CAP; j++) begin
                        if (ge[j]) begin
                            n_cell[j] = ge[j-1] ? r_cell[j-1] : r_value;
                        end
                    end
                end
            end else if (found) begin
                n_count = r_count - CW'(1);
                for (int j = 0; j < CAP - 1; j++) begin
                    if (hit_upto[j]) begin
                        n_cell[j] = r_cell[j+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CAP; j++) begin
            r_cell[j] <= n_cell[j];
        end
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.apply) begin
            r_entry <= '0;
            r_last  <= 1'b1;
            if (r_action == sli_pkg::ACT_INSERT) begin
                r_status <= full ? sli_pkg::ST_FULL : sli_pkg::ST_OK;
            end else begin
                r_status <= found ? sli_pkg::ST_OK : sli_pkg::ST_NOT_FOUND;
            end
        end else if (i_cmd.emit_empty) begin
            r_status <= sli_pkg::ST_EMPTY;
            r_entry  <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.emit_entry) begin
            r_status <= sli_pkg::ST_ENTRY;
            r_entry  <= r_cell[r_idx];
            r_last   <= dump_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.capture) begin
                r_idx <= '0;
            end else if (i_cmd.emit_entry) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.apply || i_cmd.emit_empty || i_cmd.emit_entry) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.action    = r_action;
    assign o_stat.out_free  = out_free;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.dump_last = dump_last;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_entry     = r_entry;
    assign o_last      = r_last;

endmodule

`default_nettype wire

/* rtl/sli_checker.sv */
`default_nettype none

module sli_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic [sli_pkg::STS_W-1:0]        o_status,
    input wire logic signed [sli_pkg::VAL_W-1:0] o_entry,
    input wire logic                             o_last
);

    // A stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_entry) && $stable(o_last))
        else $error("stalled result changed");

    // Only a dumped entry carries a value
    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != sli_pkg::ST_ENTRY) |-> (o_entry == '0))
        else $error("non-entry result carries a value");

    // Single-result statuses always close the item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sli_pkg::ST_OK || o_status == sli_pkg::ST_FULL ||
                        o_status == sli_pkg::ST_NOT_FOUND ||
                        o_status == sli_pkg::ST_EMPTY) |-> o_last)
        else $error("single result without last");

    // One item at a time: after an input transfer the input stalls
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // No status code beyond the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= sli_pkg::ST_EMPTY))
        else $error("undefined status code");

endmodule

bind sorted_list_insert_remove sli_checker u_sli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_entry     (o_entry),
    .o_last      (o_last)
);

`default_nettype wire

/* tb/sli_result_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the sorted list, keeps a shadow copy of the
// store, and checks every output transfer against the oldest predicted result.
module sli_result_checker
    import sli_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire logic [ACT_W-1:0]        i_action,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic [STS_W-1:0]        i_status,
    input  wire logic signed [VAL_W-1:0] i_entry,
    input  wire logic                    i_last,
    output int                           o_fail_cnt,
    output int                           o_pending
);

    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic signed [VAL_W-1:0] entry;
        logic                    last;
    } t_result;

    t_result                 due_results [$];
    t_result                 want;
    logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
    int                      shadow_cnt = 0;
    int                      fail_cnt   = 0;

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
        if (fail_cnt < 30) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
        fail_cnt++;
    endtask

    // Apply one action to the shadow store and queue the results it causes.
    task automatic predict_list_action(input logic [ACT_W-1:0] act,
                                       input logic signed [VAL_W-1:0] val);
        int pos;
        int k;
        pos = 0;
        case (act)
            ACT_INSERT: begin
                if (shadow_cnt >= CAPACITY) begin
                    due_results.push_back('{ST_FULL, '0, 1'b1});
                end else begin
                    while (pos < shadow_cnt && shadow_vals[pos] < val) pos++;
                    for (k = shadow_cnt; k > pos; k--) shadow_vals[k] = shadow_vals[k-1];
                    shadow_vals[pos] = val;
                    shadow_cnt++;
                    due_results.push_back('{ST_OK, '0, 1'b1});
                end
            end
            ACT_REMOVE: begin
                while (pos < shadow_cnt && shadow_vals[pos] != val) pos++;
                if (pos >= shadow_cnt) begin
                    due_results.push_back('{ST_NOT_FOUND, '0, 1'b1});
                end else begin
                    for (k = pos; k + 1 < shadow_cnt; k++) shadow_vals[k] = shadow_vals[k+1];
                    shadow_cnt--;
                    due_results.push_back('{ST_OK, '0, 1'b1});
                end
            end
            ACT_DUMP: begin
                if (shadow_cnt == 0) begin
                    due_results.push_back('{ST_EMPTY, '0, 1'b1});
                end else begin
                    for (k = 0; k < shadow_cnt; k++) begin
                        due_results.push_back('{ST_ENTRY, shadow_vals[k], k + 1 == shadow_cnt});
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_results.delete();
            shadow_cnt = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    if (fail_cnt < 30) begin
                        $display({"%0t: unexpected result, expected none, ",
                                  "actual status %0d entry %0d last %0d"},
                                 $time, i_status, i_entry, i_last);
                    end
                    fail_cnt++;
                end else begin
                    want = due_results.pop_front();
                    if (i_status !== want.status) note_mismatch("status", want.status, i_status);
                    if (i_entry !== want.entry) note_mismatch("entry", want.entry, i_entry);
                    if (i_last !== want.last) note_mismatch("last", want.last, i_last);
                end
            end
            if (i_in_valid && !i_in_stall) predict_list_action(i_action, i_value);
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= due_results.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

// Top of the sorted list bench: makes stimulus on the input channel, stalls
// the output channel at random, and gives the verdict from the checker's counts.
module tb;
    import sli_pkg::*;

    // Action code 3 carries no meaning; the block takes and drops it.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 370;
    localparam int POOL_SIZE    = 12;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic [ACT_W-1:0]        i_action   = ACT_INSERT;
    logic signed [VAL_W-1:0] i_value    = '0;
    logic                    i_out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [STS_W-1:0]        o_status;
    logic signed [VAL_W-1:0] o_entry;
    logic                    o_last;
    int                      fail_cnt;
    int                      pending;

    // Set for stretches with no idling on either side.
    logic                    calm = 1'b0;

    logic signed [VAL_W-1:0] value_pool [POOL_SIZE];

    sorted_list_insert_remove dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_entry     (o_entry),
        .o_last      (o_last)
    );

    sli_result_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (o_status),
        .i_entry     (o_entry),
        .i_last      (o_last),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Idle length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Mostly values from a small pool so removes hit and duplicates pile up;
    // the rest spread over the full 32-bit range.
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 25) return $urandom;
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Output stall: bursts of random length, no new burst starts while calm.
    always @(posedge i_clk) begin : out_stall_gen
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
        end else if (!calm && $urandom_range(0, 99) < 35) begin
            stall_left = pick_gap() + 1;
        end
        i_out_stall <= (stall_left > 0);
    end

    // Hold valid low for the idle length given by gap, then present one item and wait for its transfer.
    // Returns at the accepting edge with valid still high.
    task automatic push_item(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val,
                             input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int                      counted;
        int                      since_drain;
        int                      r;
        int                      k;
        bit                      fill_mode;
        bit                      calm_now;
        logic [ACT_W-1:0]        act;
        logic signed [VAL_W-1:0] val;

        value_pool[0]  = 32'sh8000_0000;
        value_pool[1]  = 32'sh8000_0001;
        value_pool[2]  = -2;
        value_pool[3]  = -1;
        value_pool[4]  = 0;
        value_pool[5]  = 1;
        value_pool[6]  = 2;
        value_pool[7]  = 32'sh7fff_fffe;
        value_pool[8]  = 32'sh7fff_ffff;
        value_pool[9]  = $urandom;
        value_pool[10] = $urandom;
        value_pool[11] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store cases first.
        push_item(ACT_DUMP, '0, pick_gap());
        push_item(ACT_REMOVE, 32'sd5, pick_gap());
        // Extremes and a duplicate.
        push_item(ACT_INSERT, 32'sh7fff_ffff, pick_gap());
        push_item(ACT_INSERT, 32'sh8000_0000, pick_gap());
        push_item(ACT_INSERT, 32'sd0, pick_gap());
        push_item(ACT_INSERT, 32'sd0, pick_gap());
        // Remove of a missing value, then the meaningless code.
        push_item(ACT_REMOVE, 32'sd7, pick_gap());
        push_item(ACT_SPARE, 32'shffff_ffff, pick_gap());
        push_item(ACT_DUMP, 32'sh5555_5555, pick_gap());
        push_item(ACT_REMOVE, 32'sd0, pick_gap());
        push_item(ACT_REMOVE, 32'sh8000_0000, pick_gap());
        // Fill to capacity, then overflow and dump the full store.
        for (k = 0; k < CAPACITY - 2; k++) begin
            push_item(ACT_INSERT, (k % 3 == 0) ? 32'sh7fff_ffff : pick_value(), pick_gap());
        end
        push_item(ACT_INSERT, -32'sd9, pick_gap());
        push_item(ACT_DUMP, '0, pick_gap());
        wait_for_results();

        // Random: alternate between filling and draining so both ends are hit.
        counted     = 0;
        since_drain = 0;
        fill_mode   = 1'b0;
        calm_now    = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 3) fill_mode = !fill_mode;
            if ($urandom_range(0, 99) < 3) begin
                calm_now = ($urandom_range(0, 3) == 0);
                calm <= calm_now;
            end
            if (since_drain >= 64) begin
                wait_for_results();
                since_drain = 0;
            end
            r = $urandom_range(0, 99);
            if (fill_mode) begin
                act = (r < 70) ? ACT_INSERT : (r < 82) ? ACT_REMOVE :
                      (r < 96) ? ACT_DUMP : ACT_SPARE;
            end else begin
                act = (r < 12) ? ACT_INSERT : (r < 82) ? ACT_REMOVE :
                      (r < 96) ? ACT_DUMP : ACT_SPARE;
            end
            val = pick_value();
            push_item(act, val, calm_now ? 0 : pick_gap());
            if (act != ACT_SPARE) begin
                counted++;
                since_drain++;
            end
        end

        // Drain, then watch a quiet channel for stray results.
        calm <= 1'b1;
        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sli_pkg.sv
rtl/sli_ctrl.sv
rtl/sli_dpath.sv
rtl/sorted_list_insert_remove.sv
rtl/sli_checker.sv
tb/sli_result_checker.sv
tb/tb.sv
